/* rtl/core/logrid_pkg.sv */
// shared types, register indexes and constants of the log-odds occupancy grid
`timescale 1ns / 1ps
`default_nettype none
package logrid_pkg;

  // port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int S_DATA_W   = 32;
  localparam int M_DATA_W   = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOGODDS_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOGODDS_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 3'd4;

  // reset values of the configuration registers
  localparam logic signed [15:0] RST_LOGODDS_MIN  = -16'sd1280;
  localparam logic [14:0]        RST_LOGODDS_MAX  = 15'd1280;
  localparam logic signed [15:0] RST_OBSTACLE_THR = 16'sd512;
  localparam logic [8:0]         RST_GRID_DIM     = 9'd256;

  // item kinds
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clear_we;
    logic capture;
    logic load;
  } logrid_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
  } logrid_sts_t;

endpackage
`default_nettype wire

/* rtl/core/logrid_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module logrid_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/logrid_ctrl.sv */
// controller of the occupancy grid: clearing pass, accept, read-modify-write
`timescale 1ns / 1ps
`default_nettype none
module logrid_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logrid_pkg::logrid_cmd_t       cmd,
  input  wire logrid_pkg::logrid_sts_t  sts
);
  import logrid_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state, state_next;
  logic       out_valid, out_valid_next;

  always_comb begin
    s_tready    = (state == ST_IDLE) && !rst;
    cmd.clear_we = (state == ST_CLEAR);
    cmd.capture  = s_tvalid && s_tready;
    cmd.load     = (state == ST_EXEC) && (!out_valid || m_tready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (sts.clear_done) state_next = ST_IDLE;
      ST_IDLE:  if (cmd.capture) state_next = ST_EXEC;
      ST_EXEC:  if (cmd.load) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    priority if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;

endmodule
`default_nettype wire

/* rtl/core/logrid_dpath.sv */
// datapath of the occupancy grid: config registers, cell store, clamp and flags
`timescale 1ns / 1ps
`default_nettype none
module logrid_dpath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [logrid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [logrid_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                               s_tuser,
  input  wire logic [logrid_pkg::S_DATA_W-1:0]    s_tdata,
  output logic      [logrid_pkg::M_DATA_W-1:0]    m_tdata,
  input  wire logrid_pkg::logrid_cmd_t            cmd,
  output logrid_pkg::logrid_sts_t                 sts
);
  import logrid_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = AW + 8;
  localparam int CW    = (VALUE_BITS > 16) ? VALUE_BITS : 16;
  localparam int SW    = CW + 1;
  localparam logic signed [SW-1:0] VHI =
    $signed({{(SW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}});
  localparam logic signed [SW-1:0] VLO = ~VHI;

  // configuration registers
  logic signed [15:0] lo_min;
  logic [14:0]        lo_max;
  logic signed [15:0] obs_thr;
  logic [8:0]         grid_w;
  logic [8:0]         grid_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_min  <= RST_LOGODDS_MIN;
      lo_max  <= RST_LOGODDS_MAX;
      obs_thr <= RST_OBSTACLE_THR;
      grid_w  <= RST_GRID_DIM;
      grid_h  <= RST_GRID_DIM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOGODDS_MIN:  lo_min  <= $signed(cfg_data);
        REG_LOGODDS_MAX:  lo_max  <= cfg_data[14:0];
        REG_OBSTACLE_THR: obs_thr <= $signed(cfg_data);
        REG_GRID_WIDTH:   grid_w  <= cfg_data[8:0];
        REG_GRID_HEIGHT:  grid_h  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // item register
  logic               mode_q;
  logic [7:0]         x_q;
  logic [7:0]         y_q;
  logic signed [15:0] change_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= s_tuser;
      x_q      <= s_tdata[7:0];
      y_q      <= s_tdata[15:8];
      change_q <= $signed(s_tdata[31:16]);
    end
  end

  // clearing pass counter
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_we) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  assign sts.clear_done = (clr_cnt == AW'(DEPTH - 1));

  // cell addressing, row-major
  logic [MW-1:0] raddr_w, waddr_w;
  logic [AW-1:0] raddr, waddr;

  always_comb begin
    raddr_w = MW'(s_tdata[15:8]) * MW'(MAX_WIDTH) + MW'(s_tdata[7:0]);
    waddr_w = MW'(y_q) * MW'(MAX_WIDTH) + MW'(x_q);
    raddr   = raddr_w[AW-1:0];
    waddr   = cmd.clear_we ? clr_cnt : waddr_w[AW-1:0];
  end

  // read-modify-write
  logic [VALUE_BITS-1:0]        rdata;
  logic signed [VALUE_BITS-1:0] old_v, new_v, res_v;
  logic signed [SW-1:0]         sum, clamped, sat;
  logic signed [SW-1:0]         min_x, max_x;
  logic signed [CW-1:0]         res_x;
  logic                         in_grid, obstacle, ram_we;
  logic [VALUE_BITS-1:0]        ram_wdata;

  always_comb begin
    in_grid = (grid_w > 9'(x_q)) && (32'(x_q) < 32'(MAX_WIDTH)) &&
              (grid_h > 9'(y_q)) && (32'(y_q) < 32'(MAX_HEIGHT));
    old_v  = $signed(rdata);
    min_x  = SW'(lo_min);
    max_x  = $signed(SW'(lo_max));
    sum    = SW'(old_v) + SW'(change_q);
    // when the bounds cross, the lower clamp wins only for a sum below it
    priority if (sum < min_x) begin
      clamped = min_x;
    end else if (sum > max_x) begin
      clamped = max_x;
    end else begin
      clamped = sum;
    end
    priority if (clamped > VHI) begin
      sat = VHI;
    end else if (clamped < VLO) begin
      sat = VLO;
    end else begin
      sat = clamped;
    end
    new_v = VALUE_BITS'(sat);
    if (!in_grid) begin
      res_v = '0;
    end else if (mode_q == MODE_QUERY) begin
      res_v = old_v;
    end else begin
      res_v = new_v;
    end
    res_x    = CW'(res_v);
    obstacle = in_grid && (res_x > CW'(obs_thr));
    ram_we   = cmd.clear_we || (cmd.load && in_grid && (mode_q == MODE_UPDATE));
    ram_wdata = cmd.clear_we ? '0 : new_v;
  end

  logrid_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (raddr),
    .rdata (rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= {6'd0, in_grid, obstacle, res_x[15:0]};
    end
  end

endmodule
`default_nettype wire

/* rtl/core/log_odds_occupancy_grid.sv */
// top level of the log-odds occupancy grid
`timescale 1ns / 1ps
`default_nettype none
// Log-odds occupancy grid: a MAX_WIDTH x MAX_HEIGHT store of signed Q8.8
// cell values in one block ram, row-major (cell_y * MAX_WIDTH + cell_x).
// An update item adds its change to the cell, clamps to [logodds_min,
// logodds_max] (if the two cross, a sum below the lower bound takes it and
// any other sum the upper bound) and writes it back; a query item only
// reads. Each item gives exactly one result with the cell value after the
// item, the obstacle flag (value strictly above the threshold) and the
// in-range flag; a cell outside the configured width or height is left
// alone and reports zero with both flags low. An item is read from the
// ram, then clamped and written back; the controller holds one item at a
// time, so a new item is not taken until the last one is written back.
// The output register lets a new item be taken while a result waits, but a
// further result cannot leave until the waiting one is taken. After reset a
// clearing pass zeroes all MAX_WIDTH * MAX_HEIGHT cells (65536 at the
// defaults), one cell a cycle, with s_tready low; config writes are taken
// throughout. Config is to be written only while idle; nothing enforces it.
module log_odds_occupancy_grid #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [logrid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [logrid_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [logrid_pkg::S_DATA_W-1:0]    s_tdata,  // cell_x, cell_y, change
  input  wire logic                               s_tuser,  // mode
  // results
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [logrid_pkg::M_DATA_W-1:0]    m_tdata   // cell_value, is_obstacle,
                                                            // in_range, zero pad
);
  import logrid_pkg::*;

  logrid_cmd_t cmd;
  logrid_sts_t sts;

  // sequencing: clearing pass, accept, read-modify-write, result transfer
  logrid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // registers, store, clamp arithmetic and result register
  logrid_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

/* rtl/core/logrid_chk.sv */
// port checker of the occupancy grid and its bind
`timescale 1ns / 1ps
`default_nettype none
module logrid_chk (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_tvalid,
  input wire logic                               s_tready,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [logrid_pkg::M_DATA_W-1:0]    m_tdata
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // out-of-range cells report zero and no obstacle
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[17] |-> m_tdata[16:0] == 17'd0)
    else $error("out-of-range result not zero");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken during read-modify-write");

  // an accepted item is followed by a waiting result
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##2 m_tvalid)
    else $error("no result after accepted item");

endmodule

bind log_odds_occupancy_grid logrid_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
